FILE: rtl/mfa_pkg.sv
// ----------------------------------------------------------------------------
// mfa_pkg: shared types and constants of the mains frequency averager
// Request and result structs, divider interface structs, arithmetic widths,
// reset values and configuration register indexes.
// ----------------------------------------------------------------------------
package mfa_pkg;

  // Reference clock and fixed-point format of the frequency.
  localparam int unsigned CLOCK_HZ    = 20000000;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned PERIOD_BITS = 24;

  // Numerator of the reciprocal: CLOCK_HZ scaled by the fraction bits.
  localparam logic [63:0] FREQ_NUM = 64'(CLOCK_HZ) << FRAC_BITS;
  localparam int unsigned NUM_W    = $clog2(FREQ_NUM + 64'd1);

  // Frequency width (16 integer bits), sum width and divider widths.
  localparam int unsigned Q_W   = 16 + FRAC_BITS;
  localparam int unsigned SUM_W = 40;
  localparam int unsigned DVD_W = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int unsigned DVS_W = PERIOD_BITS;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  // Configuration port.
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CYCLES_PER_REPORT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_REJECT_LOW        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REJECT_HIGH       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_LOW         = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_HIGH        = 3'd4;

  // Register reset values.
  localparam logic [7:0]  RST_CYCLES_PER_REPORT = 8'd60;
  localparam logic [15:0] RST_REJECT_LOW        = 16'd110;
  localparam logic [15:0] RST_REJECT_HIGH       = 16'd130;
  localparam logic [8:0]  RST_PHASE_LOW         = 9'd177;
  localparam logic [8:0]  RST_PHASE_HIGH        = 9'd181;

  // Time-of-day clock.
  localparam logic [4:0] RST_HOURS   = 5'd21;
  localparam logic [5:0] RST_MINUTES = 6'd48;
  localparam logic [5:0] RST_SECONDS = 6'd0;
  localparam logic [5:0] LAST_SECOND = 6'd59;
  localparam logic [5:0] LAST_MINUTE = 6'd59;
  localparam logic [4:0] LAST_HOUR   = 5'd23;

  // Event kinds.
  localparam logic FUNC_PERIOD = 1'b0;
  localparam logic FUNC_PHASE  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [23:0] period_count;
    logic [8:0]  phase_deg;
  } in_t;

  typedef struct packed {
    logic [31:0] avg_freq_q16;
    logic        divisor_zero;
    logic [8:0]  spurious_count;
    logic        phase_missed;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [31:0] uptime_seconds;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/mfa_div.sv
// ----------------------------------------------------------------------------
// mfa_div: shared radix-2 restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle when the
// quotient is complete. The divisor must be non-zero.
// ----------------------------------------------------------------------------
module mfa_div (
  input  logic              clk,
  input  logic              rst,
  input  mfa_pkg::div_req_t req,
  output mfa_pkg::div_rsp_t rsp
);

  logic [mfa_pkg::CNT_W-1:0] count;
  logic                      done;
  logic [mfa_pkg::DVS_W-1:0] rem;
  logic [mfa_pkg::DVD_W-1:0] dvd;
  logic [mfa_pkg::DVS_W-1:0] dvs;
  logic [mfa_pkg::DVS_W:0]   shifted;
  logic [mfa_pkg::DVS_W:0]   trial;
  logic                      no_borrow;

  always_comb begin
    shifted   = {rem, dvd[mfa_pkg::DVD_W-1]};
    trial     = shifted - {1'b0, dvs};
    no_borrow = ~trial[mfa_pkg::DVS_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == mfa_pkg::CNT_W'(1));
      if (req.start) begin
        count <= mfa_pkg::CNT_W'(mfa_pkg::DVD_W);
      end else if (count != '0) begin
        count <= count - mfa_pkg::CNT_W'(1);
      end
    end
  end

  // The partial remainder always stays below the divisor.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dvs <= req.divisor;
    end else if (count != '0) begin
      rem <= no_borrow ? trial[mfa_pkg::DVS_W-1:0] : shifted[mfa_pkg::DVS_W-1:0];
      dvd <= {dvd[mfa_pkg::DVD_W-2:0], no_borrow};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

FILE: rtl/mains_frequency_averager_core.sv
// ----------------------------------------------------------------------------
// mains_frequency_averager_core: averaging reciprocal-period mains meter
// Converts measured mains periods to Q16.16 frequencies, averages them over a
// programmable number of cycles and issues one report per interval.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on in_valid/in_stall/in_data. A phase request
// (func = 1) is taken without raising in_stall and only updates the sticky
// phase flag. A period request (func = 0) with a non-zero period is divided
// into the reference clock by a shared bit-serial divider, one quotient bit
// per cycle, and the block raises in_stall while it works. A period of
// zero is accepted and dropped. When the interval is complete the same
// divider forms the average, so a reporting request occupies the block for
// both divisions. The divider is as wide as the 41-bit numerator.
// Reports leave on out_valid/out_stall/out_data through an output register.
// The block goes on taking requests while a report waits; only a second
// report that finds the register still full holds the block until the
// first one is taken. Reset returns all counters, the phase flag and the
// time-of-day clock (21:48:00) and the configuration to their defaults.
// Configuration is written over the APB-style port; the user must write it
// only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module mains_frequency_averager_core (
  input  logic                       clk,
  input  logic                       rst,
  // Request channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mfa_pkg::in_t               in_data,
  // Report channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output mfa_pkg::out_t              out_data,
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfa_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FREQ  = 6'b000010,
    ST_ACCUM = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_AVG   = 6'b010000,
    ST_LOAD  = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [7:0]  cycles_per_report;
  logic [15:0] reject_low_hz;
  logic [15:0] reject_high_hz;
  logic [8:0]  phase_low_deg;
  logic [8:0]  phase_high_deg;

  // Interval accumulators and clock.
  logic [7:0]                cycle_count;
  logic [8:0]                spurious_total;
  logic [mfa_pkg::SUM_W-1:0] freq_sum;
  logic                      phase_flag;
  logic [4:0]                tod_hours;
  logic [5:0]                tod_minutes;
  logic [5:0]                tod_seconds;
  logic [31:0]               uptime;

  // Working registers.
  logic [mfa_pkg::Q_W-1:0] freq_q;
  logic [31:0]             avg_q;
  logic                    avg_zero;

  // Divider.
  mfa_pkg::div_req_t div_req;
  mfa_pkg::div_rsp_t div_rsp;

  logic                          in_accept;
  logic                          cfg_write;
  logic [mfa_pkg::REG_IDX_W-1:0] reg_idx;
  logic [mfa_pkg::Q_W-1:0]       freq_sat;
  logic [31:0]                   avg_sat;
  logic [mfa_pkg::Q_W-1:0]       reject_lo_q;
  logic [mfa_pkg::Q_W-1:0]       reject_hi_q;
  logic                          spurious;
  logic [8:0]                    spurious_inc;
  logic [7:0]                    half_spurious;
  logic                          divisor_le_zero;
  logic [7:0]                    avg_divisor;
  logic                          report_due;
  logic                          phase_bad;
  logic                          out_free;
  logic                          load_out;
  logic [4:0]                    hours_next;
  logic [5:0]                    minutes_next;
  logic [5:0]                    seconds_next;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_idx   = paddr[mfa_pkg::APB_AW-1:2];

  // The phase window is inclusive; an empty window flags every phase.
  assign phase_bad = (in_data.phase_deg < phase_low_deg) ||
                     (in_data.phase_deg > phase_high_deg);

  // Quotients beyond the result format are clamped to its largest value.
  assign freq_sat = (|div_rsp.quotient[mfa_pkg::DVD_W-1:mfa_pkg::Q_W]) ?
                    '1 : div_rsp.quotient[mfa_pkg::Q_W-1:0];
  assign avg_sat  = (|div_rsp.quotient[mfa_pkg::DVD_W-1:32]) ?
                    '1 : div_rsp.quotient[31:0];

  // A frequency strictly inside the reject window is a spurious crossing.
  assign reject_lo_q  = mfa_pkg::Q_W'(reject_low_hz) << mfa_pkg::FRAC_BITS;
  assign reject_hi_q  = mfa_pkg::Q_W'(reject_high_hz) << mfa_pkg::FRAC_BITS;
  assign spurious     = (freq_q > reject_lo_q) && (freq_q < reject_hi_q);
  assign spurious_inc = spurious_total + 9'd1;

  // Every pair of spurious crossings stands for one mains cycle, so the
  // average divides by the good cycles only.
  assign half_spurious   = spurious_total[8:1];
  assign divisor_le_zero = (cycle_count <= half_spurious);
  assign avg_divisor     = cycle_count - half_spurious;
  assign report_due      = (cycle_count >= cycles_per_report);

  // The report register is free when empty or being taken this cycle.
  assign out_free = ~out_valid | ~out_stall;
  assign load_out = (state == ST_LOAD) && out_free;

  // Time of day after one more second.
  always_comb begin
    hours_next   = tod_hours;
    minutes_next = tod_minutes;
    seconds_next = tod_seconds + 6'd1;
    if (tod_seconds >= mfa_pkg::LAST_SECOND) begin
      seconds_next = '0;
      minutes_next = tod_minutes + 6'd1;
      if (tod_minutes >= mfa_pkg::LAST_MINUTE) begin
        minutes_next = '0;
        hours_next   = tod_hours + 5'd1;
        if (tod_hours >= mfa_pkg::LAST_HOUR) begin
          hours_next = '0;
        end
      end
    end
  end

  // Divider requests: the reciprocal of the period, then the average.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = mfa_pkg::FREQ_NUM[mfa_pkg::DVD_W-1:0];
    div_req.divisor  = in_data.period_count[mfa_pkg::DVS_W-1:0];
    case (state)
      ST_IDLE: begin
        div_req.start = in_accept && (in_data.func == mfa_pkg::FUNC_PERIOD) &&
                        (in_data.period_count[mfa_pkg::PERIOD_BITS-1:0] != '0);
      end
      ST_CHECK: begin
        div_req.start    = report_due && ~divisor_le_zero;
        div_req.dividend = mfa_pkg::DVD_W'(freq_sum);
        div_req.divisor  = mfa_pkg::DVS_W'(avg_divisor);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  mfa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer and interval state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cycle_count    <= '0;
      spurious_total <= '0;
      freq_sum       <= '0;
      phase_flag     <= 1'b0;
      tod_hours      <= mfa_pkg::RST_HOURS;
      tod_minutes    <= mfa_pkg::RST_MINUTES;
      tod_seconds    <= mfa_pkg::RST_SECONDS;
      uptime         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_data.func == mfa_pkg::FUNC_PHASE) begin
              if (phase_bad) begin
                phase_flag <= 1'b1;
              end
            end else if (div_req.start) begin
              state <= ST_FREQ;
            end
          end
        end
        ST_FREQ: begin
          if (div_rsp.done) begin
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          if (spurious) begin
            spurious_total <= spurious_inc;
            if (!spurious_inc[0]) begin
              cycle_count <= cycle_count + 8'd1;
            end
          end else begin
            cycle_count <= cycle_count + 8'd1;
            freq_sum    <= freq_sum + mfa_pkg::SUM_W'(freq_q);
          end
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!report_due) begin
            state <= ST_IDLE;
          end else if (divisor_le_zero) begin
            state <= ST_LOAD;
          end else begin
            state <= ST_AVG;
          end
        end
        ST_AVG: begin
          if (div_rsp.done) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            cycle_count    <= '0;
            spurious_total <= '0;
            freq_sum       <= '0;
            phase_flag     <= 1'b0;
            tod_hours      <= hours_next;
            tod_minutes    <= minutes_next;
            tod_seconds    <= seconds_next;
            uptime         <= uptime + 32'd1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Quotient capture.
  always_ff @(posedge clk) begin
    if ((state == ST_FREQ) && div_rsp.done) begin
      freq_q <= freq_sat;
    end
    if (state == ST_CHECK) begin
      avg_q    <= '0;
      avg_zero <= divisor_le_zero;
    end else if ((state == ST_AVG) && div_rsp.done) begin
      avg_q <= avg_sat;
    end
  end

  // Report register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.avg_freq_q16   <= avg_q;
      out_data.divisor_zero   <= avg_zero;
      out_data.spurious_count <= spurious_total;
      out_data.phase_missed   <= phase_flag;
      out_data.hours          <= hours_next;
      out_data.minutes        <= minutes_next;
      out_data.seconds        <= seconds_next;
      out_data.uptime_seconds <= uptime + 32'd1;
    end
  end

  // Configuration registers; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cycles_per_report <= mfa_pkg::RST_CYCLES_PER_REPORT;
      reject_low_hz     <= mfa_pkg::RST_REJECT_LOW;
      reject_high_hz    <= mfa_pkg::RST_REJECT_HIGH;
      phase_low_deg     <= mfa_pkg::RST_PHASE_LOW;
      phase_high_deg    <= mfa_pkg::RST_PHASE_HIGH;
    end else if (cfg_write && pready) begin
      case (reg_idx)
        mfa_pkg::REG_CYCLES_PER_REPORT: cycles_per_report <= pwdata[7:0];
        mfa_pkg::REG_REJECT_LOW:        reject_low_hz     <= pwdata[15:0];
        mfa_pkg::REG_REJECT_HIGH:       reject_high_hz    <= pwdata[15:0];
        mfa_pkg::REG_PHASE_LOW:         phase_low_deg     <= pwdata[8:0];
        mfa_pkg::REG_PHASE_HIGH:        phase_high_deg    <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mfa_pkg::REG_CYCLES_PER_REPORT: prdata = 32'(cycles_per_report);
      mfa_pkg::REG_REJECT_LOW:        prdata = 32'(reject_low_hz);
      mfa_pkg::REG_REJECT_HIGH:       prdata = 32'(reject_high_hz);
      mfa_pkg::REG_PHASE_LOW:         prdata = 32'(phase_low_deg);
      mfa_pkg::REG_PHASE_HIGH:        prdata = 32'(phase_high_deg);
      default:                        prdata = '0;
    endcase
  end

endmodule

FILE: rtl/mfa_checker.sv
// ----------------------------------------------------------------------------
// mfa_checker: port-level checks of the mains frequency averager
// Watches the request and report channels of the top level over time.
// ----------------------------------------------------------------------------
module mfa_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input mfa_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input mfa_pkg::out_t out_data
);

  // The block is ready for a request right after reset.
  a_ready_after_reset: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("request channel stalled after reset");

  // A phase request leaves the block ready in the next cycle.
  a_phase_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.func == mfa_pkg::FUNC_PHASE)) |=> !in_stall)
    else $error("phase request held the block");

  // A non-zero period request occupies the divider.
  a_period_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.func == mfa_pkg::FUNC_PERIOD) &&
     (in_data.period_count[mfa_pkg::PERIOD_BITS-1:0] != '0)) |=> in_stall)
    else $error("period request did not start a division");

  // A report only appears at the end of a busy interval.
  a_report_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("report raised without a preceding computation");

  // A stalled report is held unchanged.
  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled report changed");

endmodule

bind mains_frequency_averager_core mfa_checker u_mfa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/mains_frequency_averager_core_tb.sv
// ----------------------------------------------------------------------------
// mains_frequency_averager_core_tb: self-checking bench for the mains averager
// Feeds period and phase requests through a bursty driver and checks every
// report against a cycle-free predictor of the averaging, the spurious
// crossing filter, the phase flag and the time-of-day clock.
// ----------------------------------------------------------------------------
module mains_frequency_averager_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Generous watchdog limit on the length of the run.
  localparam int RUN_LIMIT     = 4000000;
  // Idle cycles allowed after the last report before the block is touched.
  localparam int SETTLE_CYCLES = 200;
  // Length of the long receiver hold-off that backs the block up.
  localparam int LONG_HOLD     = 3000;
  // Reports in the final sweep, enough for the seconds to roll over.
  localparam int SWEEP_REPORTS = 60;

  localparam logic [63:0] FREQ_NUMERATOR = 64'(mfa_pkg::CLOCK_HZ) << mfa_pkg::FRAC_BITS;
  localparam logic [63:0] FREQ_CEILING   = (64'd1 << (16 + mfa_pkg::FRAC_BITS)) - 64'd1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SQUARE} stall_mode_e;

  // Block ports; the inputs are all driven to known values from time zero.
  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  mfa_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  mfa_pkg::out_t out_data;
  logic          psel      = 1'b0;
  logic          penable   = 1'b0;
  logic          pwrite    = 1'b0;
  logic [mfa_pkg::APB_AW-1:0] paddr  = '0;
  logic [31:0]   pwdata    = '0;
  logic [31:0]   prdata;
  logic          pready;

  // Requests waiting to be offered, and reports the predictor has produced.
  mfa_pkg::in_t  queued_events[$];
  mfa_pkg::out_t expected_reports[$];

  // Predictor copy of the configuration.
  logic [7:0]  cfg_cycles    = mfa_pkg::RST_CYCLES_PER_REPORT;
  logic [15:0] cfg_rej_low   = mfa_pkg::RST_REJECT_LOW;
  logic [15:0] cfg_rej_high  = mfa_pkg::RST_REJECT_HIGH;
  logic [8:0]  cfg_ph_low    = mfa_pkg::RST_PHASE_LOW;
  logic [8:0]  cfg_ph_high   = mfa_pkg::RST_PHASE_HIGH;

  // Predictor copy of the accumulators and the clock.
  logic [7:0]  cyc_count     = '0;
  logic [8:0]  spur_total    = '0;
  logic [39:0] freq_sum      = '0;
  logic        phase_flag    = 1'b0;
  logic [4:0]  tod_h         = mfa_pkg::RST_HOURS;
  logic [5:0]  tod_m         = mfa_pkg::RST_MINUTES;
  logic [5:0]  tod_s         = mfa_pkg::RST_SECONDS;
  logic [31:0] uptime_ctr    = '0;

  int err_count     = 0;
  int cycles_run    = 0;
  int burst_left    = 1;
  int gap_left      = 0;
  int hold_requests = 0;
  int holds_seen    = 0;
  int hold_left     = 0;
  int pattern_left  = 0;
  stall_mode_e pattern_mode = STALL_NONE;

  mains_frequency_averager_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Folds one accepted request into the predicted state. A period request
  // that completes the interval pushes the report it must produce and
  // clears the accumulators, exactly as the block is meant to.
  function automatic void fold_event(input mfa_pkg::in_t ev);
    logic [63:0]   freq;
    logic [63:0]   avg;
    int            good;
    mfa_pkg::out_t rep;
    if (ev.func == mfa_pkg::FUNC_PHASE) begin
      // An empty window (low above high) flags every phase.
      if (ev.phase_deg < cfg_ph_low || ev.phase_deg > cfg_ph_high) phase_flag = 1'b1;
      return;
    end
    // A zero period is taken but leaves no trace.
    if (ev.period_count == '0) return;
    freq = FREQ_NUMERATOR / 64'(ev.period_count);
    if (freq > FREQ_CEILING) freq = FREQ_CEILING;
    // Both window bounds are exclusive; only every second spurious crossing
    // counts as a mains cycle, and it adds nothing to the sum.
    if (freq > (64'(cfg_rej_low) << mfa_pkg::FRAC_BITS) &&
        freq < (64'(cfg_rej_high) << mfa_pkg::FRAC_BITS)) begin
      spur_total = spur_total + 9'd1;
      if (!spur_total[0]) cyc_count = cyc_count + 8'd1;
    end else begin
      cyc_count = cyc_count + 8'd1;
      freq_sum  = freq_sum + 40'(freq);
    end
    if (cyc_count < cfg_cycles) return;

    uptime_ctr = uptime_ctr + 32'd1;
    if (tod_s == mfa_pkg::LAST_SECOND) begin
      tod_s = '0;
      if (tod_m == mfa_pkg::LAST_MINUTE) begin
        tod_m = '0;
        tod_h = (tod_h == mfa_pkg::LAST_HOUR) ? '0 : tod_h + 5'd1;
      end else begin
        tod_m = tod_m + 6'd1;
      end
    end else begin
      tod_s = tod_s + 6'd1;
    end

    rep  = '0;
    good = int'(cyc_count) - int'(spur_total >> 1);
    if (good <= 0) begin
      rep.divisor_zero = 1'b1;
    end else begin
      avg = 64'(freq_sum) / 64'(good);
      if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
      rep.avg_freq_q16 = avg[31:0];
    end
    rep.spurious_count = spur_total;
    rep.phase_missed   = phase_flag;
    rep.hours          = tod_h;
    rep.minutes        = tod_m;
    rep.seconds        = tod_s;
    rep.uptime_seconds = uptime_ctr;
    expected_reports.push_back(rep);

    cyc_count  = '0;
    spur_total = '0;
    freq_sum   = '0;
    phase_flag = 1'b0;
  endfunction

  // Random request. Most are plausible mains periods or periods that land
  // close to the reject window, the rest are phase events, zero periods,
  // arbitrary periods and very short ones that saturate the frequency.
  function automatic mfa_pkg::in_t make_event(input bit mains_only);
    mfa_pkg::in_t ev;
    int unsigned  roll;
    int unsigned  lo;
    int unsigned  hi;
    longint       per;
    ev.func         = mfa_pkg::FUNC_PERIOD;
    ev.period_count = 24'($urandom_range(300000, 450000));
    ev.phase_deg    = 9'($urandom_range(0, 359));
    roll = mains_only ? 99 : $urandom_range(0, 99);
    if (roll < 20) begin
      ev.func         = mfa_pkg::FUNC_PHASE;
      ev.period_count = 24'($urandom);
      if (roll < 10) begin
        lo = (cfg_ph_low > 2) ? cfg_ph_low - 2 : 0;
        hi = (cfg_ph_high < 357) ? cfg_ph_high + 2 : 359;
        if (hi < lo) hi = lo;
        ev.phase_deg = 9'($urandom_range(hi, lo));
      end
    end else if (roll < 25) begin
      ev.period_count = '0;
    end else if (roll < 50) begin
      lo = (cfg_rej_low > 2) ? cfg_rej_low - 2 : 1;
      hi = cfg_rej_high + 2;
      if (hi < lo) hi = lo;
      per = longint'(mfa_pkg::CLOCK_HZ / $urandom_range(hi, lo)) +
            longint'($urandom_range(0, 4000)) - 2000;
      if (per < 1) per = 1;
      if (per > 24'hFF_FFFF) per = 24'hFF_FFFF;
      ev.period_count = 24'(per);
    end else if (roll < 62) begin
      ev.period_count = 24'($urandom);
    end else if (roll < 70) begin
      ev.period_count = 24'($urandom_range(1, 1000));
    end
    return ev;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("report field %s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // Request driver. Items go out in bursts of random length separated by
  // random gaps; a stalled request keeps its payload and its valid.
  always @(posedge clk) begin : request_driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) fold_event(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_events.size() != 0) begin
          in_data  <= queued_events.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // One burst in four runs long with no idling at all.
            burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor. It checks every accepted report against the oldest
  // expectation and drives the stall pattern of the receiving side.
  always @(posedge clk) begin : report_monitor
    mfa_pkg::out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("report with no expectation waiting: 0x%0h", out_data);
          err_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("avg_freq_q16",   want.avg_freq_q16,   out_data.avg_freq_q16);
          check_field("divisor_zero",   32'(want.divisor_zero),
                      32'(out_data.divisor_zero));
          check_field("spurious_count", 32'(want.spurious_count),
                      32'(out_data.spurious_count));
          check_field("phase_missed",   32'(want.phase_missed),
                      32'(out_data.phase_missed));
          check_field("hours",          32'(want.hours),   32'(out_data.hours));
          check_field("minutes",        32'(want.minutes), 32'(out_data.minutes));
          check_field("seconds",        32'(want.seconds), 32'(out_data.seconds));
          check_field("uptime_seconds", want.uptime_seconds, out_data.uptime_seconds);
        end
      end
      if (holds_seen != hold_requests) begin
        hold_left  = LONG_HOLD;
        holds_seen = hold_requests;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_mode = stall_mode_e'($urandom_range(0, 3));
          pattern_left = $urandom_range(16, 300);
        end
        pattern_left--;
        case (pattern_mode)
          STALL_NONE: begin
            out_stall <= 1'b0;
          end
          STALL_LIGHT: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          STALL_HEAVY: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= pattern_left[2];
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles_run <= cycles_run + 1;
    if (cycles_run == RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Register write over the configuration port: a setup cycle, then an
  // access cycle, with the register taken at the edge that ends it.
  task automatic write_reg(input logic [mfa_pkg::REG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mfa_pkg::REG_CYCLES_PER_REPORT: cfg_cycles   = val[7:0];
      mfa_pkg::REG_REJECT_LOW:        cfg_rej_low  = val[15:0];
      mfa_pkg::REG_REJECT_HIGH:       cfg_rej_high = val[15:0];
      mfa_pkg::REG_PHASE_LOW:         cfg_ph_low   = val[8:0];
      mfa_pkg::REG_PHASE_HIGH:        cfg_ph_high  = val[8:0];
      default: ;
    endcase
  endtask

  task automatic queue_random(input int count, input bit mains_only);
    @(negedge clk);
    repeat (count) queued_events.push_back(make_event(mains_only));
  endtask

  task automatic push_event(input logic func, input int unsigned period,
                            input int unsigned phase);
    mfa_pkg::in_t ev;
    ev.func         = func;
    ev.period_count = 24'(period);
    ev.phase_deg    = 9'(phase);
    queued_events.push_back(ev);
  endtask

  // Waits until every request has gone in and every report has come out,
  // then gives a request that produces no report time to finish.
  task automatic settle();
    do @(negedge clk);
    while (queued_events.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int          lo;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: one report per sixty counted cycles.
    queue_random(140, 1'b0);
    settle();

    // Directed requests with one report per counted cycle and a reject
    // window whose bounds map onto whole periods, so that frequencies on
    // the bounds themselves can be hit.
    write_reg(mfa_pkg::REG_CYCLES_PER_REPORT, 1);
    write_reg(mfa_pkg::REG_REJECT_LOW, 100);
    write_reg(mfa_pkg::REG_REJECT_HIGH, 125);
    @(negedge clk);
    push_event(mfa_pkg::FUNC_PHASE, 24'hFF_FFFF, 176);  // just below the phase window
    push_event(mfa_pkg::FUNC_PHASE, 0, 177);
    push_event(mfa_pkg::FUNC_PHASE, 0, 181);
    push_event(mfa_pkg::FUNC_PHASE, 0, 0);
    push_event(mfa_pkg::FUNC_PHASE, 0, 359);
    push_event(mfa_pkg::FUNC_PERIOD, 0, 359);           // zero period is dropped
    push_event(mfa_pkg::FUNC_PERIOD, 200000, 0);        // exactly on the lower bound
    push_event(mfa_pkg::FUNC_PERIOD, 160000, 0);        // exactly on the upper bound
    push_event(mfa_pkg::FUNC_PERIOD, 199999, 0);        // spurious, first of a pair
    push_event(mfa_pkg::FUNC_PERIOD, 160001, 0);        // pair completes: divisor zero
    push_event(mfa_pkg::FUNC_PERIOD, 199999, 0);        // odd spurious before a good cycle
    push_event(mfa_pkg::FUNC_PERIOD, 200000, 0);
    push_event(mfa_pkg::FUNC_PERIOD, 1, 0);             // saturated frequency
    push_event(mfa_pkg::FUNC_PERIOD, 305, 0);
    push_event(mfa_pkg::FUNC_PERIOD, 306, 0);
    push_event(mfa_pkg::FUNC_PERIOD, 24'hFF_FFFF, 0);   // lowest frequency
    push_event(mfa_pkg::FUNC_PHASE, 24'h55_5555, 182);  // just above the phase window
    push_event(mfa_pkg::FUNC_PERIOD, 24'h80_0000, 9'h0AA);
    push_event(mfa_pkg::FUNC_PERIOD, 24'h55_5555, 9'h155);
    push_event(mfa_pkg::FUNC_PERIOD, 24'hAA_AAAA, 9'h0AA);
    push_event(mfa_pkg::FUNC_PHASE, 24'hAA_AAAA, 180);
    push_event(mfa_pkg::FUNC_PERIOD, 400000, 0);
    settle();

    // Longest interval with nothing rejected and every phase accepted.
    write_reg(mfa_pkg::REG_CYCLES_PER_REPORT, 255);
    write_reg(mfa_pkg::REG_REJECT_LOW, 0);
    write_reg(mfa_pkg::REG_REJECT_HIGH, 0);
    write_reg(mfa_pkg::REG_PHASE_LOW, 0);
    write_reg(mfa_pkg::REG_PHASE_HIGH, 359);
    queue_random(260, 1'b1);
    settle();

    // Widest reject window and an empty phase window that flags everything.
    write_reg(mfa_pkg::REG_CYCLES_PER_REPORT, 1);
    write_reg(mfa_pkg::REG_REJECT_HIGH, 65535);
    write_reg(mfa_pkg::REG_PHASE_LOW, 359);
    write_reg(mfa_pkg::REG_PHASE_HIGH, 0);
    queue_random(40, 1'b0);
    settle();

    // The receiver holds off for a long stretch while requests keep coming,
    // so the output register fills and the block has to stall its input.
    write_reg(mfa_pkg::REG_REJECT_LOW, 65535);
    @(negedge clk);
    hold_requests++;
    queue_random(40, 1'b1);
    settle();

    // A few random settings around ordinary mains operation.
    repeat (4) begin
      lo = $urandom_range(40, 120);
      write_reg(mfa_pkg::REG_CYCLES_PER_REPORT, $urandom_range(1, 8));
      write_reg(mfa_pkg::REG_REJECT_LOW, lo);
      write_reg(mfa_pkg::REG_REJECT_HIGH, lo + $urandom_range(0, 40));
      lo = $urandom_range(150, 200);
      write_reg(mfa_pkg::REG_PHASE_LOW, lo);
      write_reg(mfa_pkg::REG_PHASE_HIGH, lo + $urandom_range(0, 20));
      queue_random(25, 1'b0);
      settle();
    end

    // One report per request for a whole minute, so that the seconds roll
    // over into the minutes at least once.
    write_reg(mfa_pkg::REG_CYCLES_PER_REPORT, 1);
    write_reg(mfa_pkg::REG_REJECT_LOW, 0);
    write_reg(mfa_pkg::REG_REJECT_HIGH, 0);
    queue_random(SWEEP_REPORTS, 1'b1);
    settle();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
